// ----- hw/rtl/nfcp_pkg.sv -----
// nfcp_pkg: shared types and codes of the response frame parser.
// Used by the frame state machine, the output register and the top level.
`timescale 1ns / 1ps

package nfcp_pkg;

	// Input item kinds
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	// Frame end status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_NOSPACE = 2'd3;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_SENT_COMMAND     = 2'd0;
	localparam logic [1:0] CFG_FRAME_IDENTIFIER = 2'd1;
	localparam logic [1:0] CFG_BYTE_TIMEOUT     = 2'd2;
	localparam logic [1:0] CFG_BUFFER_CAPACITY  = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// Frame bytes
	localparam logic [7:0] PREAMBLE_END = 8'hFF;
	localparam logic [7:0] MIN_LENGTH   = 8'd2;

	typedef struct packed {
		logic [7:0]  sent_command;
		logic [7:0]  frame_identifier;
		logic [15:0] byte_timeout;
		logic [7:0]  buffer_capacity;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [1:0] status;
		logic [7:0] payload_length;
	} res_t;

endpackage

// ----- hw/rtl/nfcp_if.sv -----
// nfcp_if: valid/ready channels for input items and result items.
// Standalone; the payload widths match the fields used with nfcp_pkg.
`timescale 1ns / 1ps

interface nfcp_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface nfcp_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [1:0] status;
	logic [7:0] payload_length;

	modport source (output valid, output kind, output payload_byte, output payload_index,
		output status, output payload_length, input ready);
	modport sink (input valid, input kind, input payload_byte, input payload_index,
		input status, input payload_length, output ready);
endinterface

// ----- hw/rtl/nfcp_frame_fsm.sv -----
// nfcp_frame_fsm: frame state and the per-item parse logic.
// Depends on nfcp_pkg (codes, cfg_t, res_t).
`timescale 1ns / 1ps

module nfcp_frame_fsm
	import nfcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] cmd,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output logic       res_vld,
	output res_t       res
);

	typedef enum logic [2:0] {
		PH_DONE,
		PH_PRE,
		PH_LEN,
		PH_CMD,
		PH_DATA,
		PH_TAIL
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  pair_q, pair_n;
	logic [7:0]  held_q, held_n;
	logic        pre_bad_q, pre_bad_n;
	logic [7:0]  total_q, total_n;
	logic [7:0]  count_q, count_n;
	logic [7:0]  sum_q, sum_n;
	logic [15:0] tick_q, tick_n;

	logic [7:0]  rsp_code;
	logic [7:0]  want_pre;
	logic        pre_bad_now;
	logic [7:0]  count_inc;
	logic [15:0] tick_inc;

	assign rsp_code    = cfg.sent_command + 8'd1;
	assign want_pre    = (pair_q == 2'd2) ? PREAMBLE_END : 8'h00;
	assign pre_bad_now = pre_bad_q | (rx_byte != want_pre);
	assign count_inc   = count_q + 8'd1;
	assign tick_inc    = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;

	// Next state and result for the item being processed
	always_comb begin
		phase_n   = phase_q;
		pair_n    = pair_q;
		held_n    = held_q;
		pre_bad_n = pre_bad_q;
		total_n   = total_q;
		count_n   = count_q;
		sum_n     = sum_q;
		tick_n    = tick_q;
		res_vld   = 1'b0;
		res       = '0;
		res.kind  = KIND_END;

		if (step) begin
			if (cmd == CMD_START) begin
				phase_n   = PH_PRE;
				pair_n    = 2'd0;
				held_n    = 8'd0;
				pre_bad_n = 1'b0;
				total_n   = 8'd0;
				count_n   = 8'd0;
				sum_n     = 8'd0;
				tick_n    = 16'd0;
			end else if (phase_q != PH_DONE && cmd == CMD_TICK) begin
				tick_n = tick_inc;
				if (cfg.byte_timeout != 16'd0 && tick_inc >= cfg.byte_timeout) begin
					res_vld    = 1'b1;
					res.status = ST_TIMEOUT;
				end
			end else if (phase_q != PH_DONE && cmd == CMD_BYTE) begin
				tick_n = 16'd0;
				unique case (phase_q)
					PH_PRE: begin
						pre_bad_n = pre_bad_now;
						if (pair_q != 2'd2) begin
							pair_n = pair_q + 2'd1;
						end else if (pre_bad_now) begin
							res_vld    = 1'b1;
							res.status = ST_INVALID;
						end else begin
							phase_n = PH_LEN;
							pair_n  = 2'd0;
						end
					end
					PH_LEN: begin
						if (pair_q == 2'd0) begin
							held_n = rx_byte;
							pair_n = 2'd1;
						end else if ((held_q + rx_byte) != 8'd0 || held_q < MIN_LENGTH) begin
							res_vld    = 1'b1;
							res.status = ST_INVALID;
						end else begin
							total_n = held_q - MIN_LENGTH;
							phase_n = PH_CMD;
							pair_n  = 2'd0;
							if ((held_q - MIN_LENGTH) > cfg.buffer_capacity) begin
								res_vld    = 1'b1;
								res.status = ST_NOSPACE;
							end
						end
					end
					PH_CMD: begin
						if (pair_q == 2'd0) begin
							held_n = rx_byte;
							pair_n = 2'd1;
						end else if (held_q != cfg.frame_identifier || rx_byte != rsp_code) begin
							res_vld    = 1'b1;
							res.status = ST_INVALID;
						end else begin
							sum_n   = cfg.frame_identifier + rsp_code;
							count_n = 8'd0;
							pair_n  = 2'd0;
							phase_n = (total_q == 8'd0) ? PH_TAIL : PH_DATA;
						end
					end
					PH_DATA: begin
						res_vld           = 1'b1;
						res.kind          = KIND_DATA;
						res.payload_byte  = rx_byte;
						res.payload_index = count_q;
						sum_n             = sum_q + rx_byte;
						count_n           = count_inc;
						if (count_inc >= total_q) begin
							phase_n = PH_TAIL;
							pair_n  = 2'd0;
						end
					end
					PH_TAIL: begin
						if (pair_q == 2'd0) begin
							held_n = rx_byte;
							pair_n = 2'd1;
						end else if ((sum_q + held_q) != 8'd0 || rx_byte != 8'd0) begin
							res_vld    = 1'b1;
							res.status = ST_INVALID;
						end else begin
							res_vld            = 1'b1;
							res.status         = ST_OK;
							res.payload_length = total_q;
						end
					end
					default: begin
					end
				endcase
			end

			// Any frame end result closes the frame
			if (res_vld && res.kind == KIND_END) begin
				phase_n = PH_DONE;
				pair_n  = 2'd0;
			end
		end
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DONE;
			pair_q    <= 2'd0;
			held_q    <= 8'd0;
			pre_bad_q <= 1'b0;
			total_q   <= 8'd0;
			count_q   <= 8'd0;
			sum_q     <= 8'd0;
			tick_q    <= 16'd0;
		end else begin
			phase_q   <= phase_n;
			pair_q    <= pair_n;
			held_q    <= held_n;
			pre_bad_q <= pre_bad_n;
			total_q   <= total_n;
			count_q   <= count_n;
			sum_q     <= sum_n;
			tick_q    <= tick_n;
		end
	end

`ifndef SYNTHESIS
	// A frame end result always leaves the parser idle
	a_end_goes_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_vld && res.kind == KIND_END |=> phase_q == PH_DONE)
		else $error("frame end did not return to idle");

	// Payload index never reaches the announced length
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> count_q < total_q)
		else $error("payload count beyond frame length");

	// Only the preamble uses a three-byte group
	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_PRE |-> pair_q <= 2'd1)
		else $error("pair position out of range");

	// Payload byte results come only from the payload phase
	a_data_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_vld && res.kind == KIND_DATA |-> phase_q == PH_DATA)
		else $error("payload result outside payload phase");
`endif

endmodule

// ----- hw/rtl/nfcp_out_reg.sv -----
// nfcp_out_reg: result register driving the result channel.
// Depends on nfcp_pkg (res_t) and nfcp_if.
`timescale 1ns / 1ps

module nfcp_out_reg
	import nfcp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  res_t                 res,
	output logic                 free,
	nfcp_result_if.source        result
);

	logic valid_q;
	res_t data_q;

	// Slot is free when empty or being drained this cycle
	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= res;
		end
	end

	assign result.valid          = valid_q;
	assign result.kind           = data_q.kind;
	assign result.payload_byte   = data_q.payload_byte;
	assign result.payload_index  = data_q.payload_index;
	assign result.status         = data_q.status;
	assign result.payload_length = data_q.payload_length;

endmodule

// ----- hw/rtl/nfcp_response_frame_parser.sv -----
// Path: an accepted item is held in the input register, and the combinational parse
// logic between the two registers loads any result into the result register.
// Throughput: one item per cycle while nothing stalls; a stalled result register
// holds back the input register and then the input channel.
// Reset (arst_n, asynchronous, active low) leaves the parser idle, ignoring
// bytes and ticks until a start item, with configuration at its reset values.
`timescale 1ns / 1ps

module nfc_response_frame_parser
	import nfcp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	nfcp_item_if.sink              item,
	nfcp_result_if.source          result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t       cfg_q;
	logic       vld_s1;
	logic [1:0] cmd_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       step;
	logic       res_vld;
	res_t       res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sent_command     <= 8'd0;
			cfg_q.frame_identifier <= 8'd213;
			cfg_q.byte_timeout     <= 16'd0;
			cfg_q.buffer_capacity  <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SENT_COMMAND:     cfg_q.sent_command     <= cfg_wdata[7:0];
				CFG_FRAME_IDENTIFIER: cfg_q.frame_identifier <= cfg_wdata[7:0];
				CFG_BYTE_TIMEOUT:     cfg_q.byte_timeout     <= cfg_wdata;
				CFG_BUFFER_CAPACITY:  cfg_q.buffer_capacity  <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: refills whenever its item moves on
	assign step       = vld_s1 && out_free;
	assign item.ready = !vld_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1  <= item.cmd;
			byte_s1 <= item.rx_byte;
		end
	end

	nfcp_frame_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.cmd     (cmd_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res_vld (res_vld),
		.res     (res)
	);

	nfcp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && res_vld),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

endmodule
